/* design/nvta_pkg.sv */
// ----------------------------------------------------------------------------
// nvta_pkg: shared types and constants of the node value table averager
// Table depth, field widths, entry layout, status codes and sequencer states.
// ----------------------------------------------------------------------------
package nvta_pkg;

  localparam int ENTRIES = 32;

  localparam int ID_W     = 29;
  localparam int TEMP_W   = 16;
  localparam int LIGHT_W  = 16;
  localparam int POT_W    = 8;
  localparam int OWN_W    = 10;
  localparam int NCOUNT_W = 6;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int DIV_W = $clog2(ENTRIES + 2);
  localparam int SUM_W = TEMP_W + CNT_W;
  localparam int DCNT_W = $clog2(SUM_W);

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CNT_W-1:0]    count_t;
  typedef logic [DIV_W-1:0]    divisor_t;
  typedef logic [SUM_W-1:0]    sum_t;
  typedef logic [DCNT_W-1:0]   dcnt_t;
  typedef logic [NCOUNT_W-1:0] ncount_t;

  localparam count_t COUNT_MAX = count_t'(ENTRIES);
  localparam dcnt_t  DCNT_LAST = dcnt_t'(SUM_W - 1);

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [TEMP_W-1:0]  temp;
    logic [LIGHT_W-1:0] light;
    logic [POT_W-1:0]   pot;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    STAT_UPDATED = 2'd0,
    STAT_ADDED   = 2'd1,
    STAT_DROPPED = 2'd2,
    STAT_REPORT  = 2'd3
  } status_t;

  typedef enum logic {
    OP_MESSAGE = 1'b0,
    OP_REPORT  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    SEL_TEMP  = 2'd0,
    SEL_LIGHT = 2'd1,
    SEL_POT   = 2'd2
  } avg_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_APPEND,
    S_DIV_START,
    S_DIV_WAIT,
    S_RESULT
  } seq_state_t;

  typedef struct packed {
    logic     start;
    sum_t     dividend;
    divisor_t divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    sum_t quotient;
  } div_rsp_t;

endpackage

/* design/nvta_if.sv */
// ----------------------------------------------------------------------------
// nvta_if: channel interfaces of the node value table averager
// Valid/ready channels for incoming items and for result items.
// ----------------------------------------------------------------------------
interface nvta_in_if;
  logic                              valid;
  logic                              ready;
  logic                              operation;
  logic [nvta_pkg::ID_W-1:0]         node_id;
  logic [nvta_pkg::TEMP_W-1:0]       rx_temp;
  logic [nvta_pkg::LIGHT_W-1:0]      rx_light;
  logic [nvta_pkg::POT_W-1:0]        rx_pot;
  logic [nvta_pkg::OWN_W-1:0]        own_temp;
  logic [nvta_pkg::OWN_W-1:0]        own_light;
  logic [nvta_pkg::POT_W-1:0]        own_pot;

  modport source (
    output valid, operation, node_id, rx_temp, rx_light, rx_pot,
           own_temp, own_light, own_pot,
    input  ready
  );
  modport sink (
    input  valid, operation, node_id, rx_temp, rx_light, rx_pot,
           own_temp, own_light, own_pot,
    output ready
  );
endinterface

interface nvta_out_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        status;
  logic [nvta_pkg::NCOUNT_W-1:0]     node_count;
  logic [nvta_pkg::TEMP_W-1:0]       avg_temp;
  logic [nvta_pkg::LIGHT_W-1:0]      avg_light;
  logic [nvta_pkg::POT_W-1:0]        avg_pot;

  modport source (
    output valid, status, node_count, avg_temp, avg_light, avg_pot,
    input  ready
  );
  modport sink (
    input  valid, status, node_count, avg_temp, avg_light, avg_pot,
    output ready
  );
endinterface

/* design/node_value_table_averager.sv */
// ----------------------------------------------------------------------------
// node_value_table_averager: table of remote node readings with averaging
// Updates or appends node entries and reports truncated means on request.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one item per transfer. A message (operation 0) searches the
//   table for node_id and overwrites that entry, or appends a new one; when
//   the table holds ENTRIES nodes an unknown node is dropped. A report
//   (operation 1) sums the table plus the own readings, divides each sum by
//   count plus one and empties the table.
//   out_ch returns exactly one result per item.
//   The search or summation reads the single table RAM port, one entry at a
//   time, with S_READ followed by S_CHECK for each entry. A report runs the
//   serial divider, one quotient bit per cycle, three times, once per mean.
//   in_ch.ready is high only while the block is idle; a new item is taken
//   while the previous result still waits in the output register.
//   A stalled out_ch holds the result and the block waits before loading the
//   next one. Reset empties the table; the RAM itself is not cleared.
// ----------------------------------------------------------------------------
module node_value_table_averager (
  input  logic      clk,
  input  logic      rst_n,
  nvta_in_if.sink   in_ch,
  nvta_out_if.source out_ch
);

  nvta_pkg::seq_state_t state_r, state_nxt;
  nvta_pkg::count_t     count_r, count_nxt;
  nvta_pkg::idx_t       k_r, k_nxt;
  nvta_pkg::avg_sel_t   sel_r, sel_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic                          op_r, op_nxt;
  logic [nvta_pkg::ID_W-1:0]     id_r, id_nxt;
  logic [nvta_pkg::TEMP_W-1:0]   temp_r, temp_nxt;
  logic [nvta_pkg::LIGHT_W-1:0]  light_r, light_nxt;
  logic [nvta_pkg::POT_W-1:0]    pot_r, pot_nxt;
  nvta_pkg::sum_t                sum_t_r, sum_t_nxt;
  nvta_pkg::sum_t                sum_l_r, sum_l_nxt;
  nvta_pkg::sum_t                sum_p_r, sum_p_nxt;
  logic [nvta_pkg::TEMP_W-1:0]   avg_t_r, avg_t_nxt;
  logic [nvta_pkg::LIGHT_W-1:0]  avg_l_r, avg_l_nxt;
  logic [nvta_pkg::POT_W-1:0]    avg_p_r, avg_p_nxt;
  nvta_pkg::status_t             status_r, status_nxt;

  nvta_pkg::status_t             out_status_r, out_status_nxt;
  nvta_pkg::ncount_t             out_count_r, out_count_nxt;
  logic [nvta_pkg::TEMP_W-1:0]   out_avg_t_r, out_avg_t_nxt;
  logic [nvta_pkg::LIGHT_W-1:0]  out_avg_l_r, out_avg_l_nxt;
  logic [nvta_pkg::POT_W-1:0]    out_avg_p_r, out_avg_p_nxt;

  logic                          ram_we;
  nvta_pkg::idx_t                ram_waddr;
  nvta_pkg::entry_t              ram_wdata;
  logic                          ram_re;
  nvta_pkg::entry_t              rd_entry;
  logic [nvta_pkg::ENTRY_W-1:0]  ram_rdata;

  nvta_pkg::div_req_t            div_req;
  nvta_pkg::div_rsp_t            div_rsp;

  logic                          last_entry;
  logic                          out_free;

  nvta_ram #(
    .WIDTH (nvta_pkg::ENTRY_W),
    .DEPTH (nvta_pkg::ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (k_r),
    .rdata (ram_rdata)
  );

  nvta_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign rd_entry   = nvta_pkg::entry_t'(ram_rdata);
  assign last_entry = ((nvta_pkg::count_t'(k_r) + nvta_pkg::count_t'(1)) == count_r);
  assign out_free   = !out_valid_r || out_ch.ready;

  assign in_ch.ready       = (state_r == nvta_pkg::S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.node_count = out_count_r;
  assign out_ch.avg_temp   = out_avg_t_r;
  assign out_ch.avg_light  = out_avg_l_r;
  assign out_ch.avg_pot    = out_avg_p_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    temp_nxt      = temp_r;
    light_nxt     = light_r;
    pot_nxt       = pot_r;
    sum_t_nxt     = sum_t_r;
    sum_l_nxt     = sum_l_r;
    sum_p_nxt     = sum_p_r;
    avg_t_nxt     = avg_t_r;
    avg_l_nxt     = avg_l_r;
    avg_p_nxt     = avg_p_r;
    status_nxt    = status_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_avg_t_nxt  = out_avg_t_r;
    out_avg_l_nxt  = out_avg_l_r;
    out_avg_p_nxt  = out_avg_p_r;

    ram_we    = 1'b0;
    ram_waddr = k_r;
    ram_wdata = '{id: id_r, temp: temp_r, light: light_r, pot: pot_r};
    ram_re    = 1'b0;

    div_req.start    = 1'b0;
    div_req.divisor  = nvta_pkg::divisor_t'(count_r) + nvta_pkg::divisor_t'(1);
    unique case (sel_r)
      nvta_pkg::SEL_TEMP:  div_req.dividend = sum_t_r;
      nvta_pkg::SEL_LIGHT: div_req.dividend = sum_l_r;
      default:             div_req.dividend = sum_p_r;
    endcase

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      nvta_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt    = in_ch.operation;
          id_nxt    = in_ch.node_id;
          temp_nxt  = in_ch.rx_temp;
          light_nxt = in_ch.rx_light;
          pot_nxt   = in_ch.rx_pot;
          sum_t_nxt = nvta_pkg::sum_t'(in_ch.own_temp);
          sum_l_nxt = nvta_pkg::sum_t'(in_ch.own_light);
          sum_p_nxt = nvta_pkg::sum_t'(in_ch.own_pot);
          k_nxt     = '0;
          sel_nxt   = nvta_pkg::SEL_TEMP;
          if (count_r == '0) begin
            state_nxt = (in_ch.operation == nvta_pkg::OP_REPORT) ? nvta_pkg::S_DIV_START
                                                                 : nvta_pkg::S_APPEND;
          end else begin
            state_nxt = nvta_pkg::S_READ;
          end
        end
      end
      nvta_pkg::S_READ: begin
        ram_re    = 1'b1;
        state_nxt = nvta_pkg::S_CHECK;
      end
      nvta_pkg::S_CHECK: begin
        if (op_r == nvta_pkg::OP_REPORT) begin
          sum_t_nxt = sum_t_r + nvta_pkg::sum_t'(rd_entry.temp);
          sum_l_nxt = sum_l_r + nvta_pkg::sum_t'(rd_entry.light);
          sum_p_nxt = sum_p_r + nvta_pkg::sum_t'(rd_entry.pot);
          if (last_entry) begin
            state_nxt = nvta_pkg::S_DIV_START;
          end else begin
            k_nxt     = k_r + nvta_pkg::idx_t'(1);
            state_nxt = nvta_pkg::S_READ;
          end
        end else if (rd_entry.id == id_r) begin
          ram_we     = 1'b1;
          status_nxt = nvta_pkg::STAT_UPDATED;
          state_nxt  = nvta_pkg::S_RESULT;
        end else if (last_entry) begin
          state_nxt = nvta_pkg::S_APPEND;
        end else begin
          k_nxt     = k_r + nvta_pkg::idx_t'(1);
          state_nxt = nvta_pkg::S_READ;
        end
      end
      nvta_pkg::S_APPEND: begin
        if (count_r < nvta_pkg::COUNT_MAX) begin
          ram_we     = 1'b1;
          ram_waddr  = count_r[nvta_pkg::IDX_W-1:0];
          count_nxt  = count_r + nvta_pkg::count_t'(1);
          status_nxt = nvta_pkg::STAT_ADDED;
        end else begin
          status_nxt = nvta_pkg::STAT_DROPPED;
        end
        state_nxt = nvta_pkg::S_RESULT;
      end
      nvta_pkg::S_DIV_START: begin
        div_req.start = 1'b1;
        state_nxt     = nvta_pkg::S_DIV_WAIT;
      end
      nvta_pkg::S_DIV_WAIT: begin
        if (div_rsp.done) begin
          unique case (sel_r)
            nvta_pkg::SEL_TEMP: begin
              avg_t_nxt = div_rsp.quotient[nvta_pkg::TEMP_W-1:0];
              sel_nxt   = nvta_pkg::SEL_LIGHT;
              state_nxt = nvta_pkg::S_DIV_START;
            end
            nvta_pkg::SEL_LIGHT: begin
              avg_l_nxt = div_rsp.quotient[nvta_pkg::LIGHT_W-1:0];
              sel_nxt   = nvta_pkg::SEL_POT;
              state_nxt = nvta_pkg::S_DIV_START;
            end
            default: begin
              avg_p_nxt  = div_rsp.quotient[nvta_pkg::POT_W-1:0];
              status_nxt = nvta_pkg::STAT_REPORT;
              state_nxt  = nvta_pkg::S_RESULT;
            end
          endcase
        end
      end
      nvta_pkg::S_RESULT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_count_nxt  = nvta_pkg::ncount_t'(count_r);
          if (op_r == nvta_pkg::OP_REPORT) begin
            out_avg_t_nxt = avg_t_r;
            out_avg_l_nxt = avg_l_r;
            out_avg_p_nxt = avg_p_r;
            count_nxt     = '0;
          end else begin
            out_avg_t_nxt = '0;
            out_avg_l_nxt = '0;
            out_avg_p_nxt = '0;
          end
          state_nxt = nvta_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = nvta_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nvta_pkg::S_IDLE;
      count_r     <= '0;
      k_r         <= '0;
      sel_r       <= nvta_pkg::SEL_TEMP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      k_r         <= k_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    id_r         <= id_nxt;
    temp_r       <= temp_nxt;
    light_r      <= light_nxt;
    pot_r        <= pot_nxt;
    sum_t_r      <= sum_t_nxt;
    sum_l_r      <= sum_l_nxt;
    sum_p_r      <= sum_p_nxt;
    avg_t_r      <= avg_t_nxt;
    avg_l_r      <= avg_l_nxt;
    avg_p_r      <= avg_p_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_avg_t_r  <= out_avg_t_nxt;
    out_avg_l_r  <= out_avg_l_nxt;
    out_avg_p_r  <= out_avg_p_nxt;
  end

  // The table never holds more nodes than it has rows.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= nvta_pkg::COUNT_MAX)
    else $error("entry count exceeds table depth");

  // Writes land on a valid entry or on the first free row.
  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (nvta_pkg::count_t'(ram_waddr) <= count_r))
    else $error("table write beyond the fill level");

  // A report result empties the table once it is loaded for transfer.
  a_report_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nvta_pkg::S_RESULT && op_r == nvta_pkg::OP_REPORT && out_free)
      |=> (count_r == '0))
    else $error("report did not empty the table");

  // The divider only finishes while the sequencer waits for it.
  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == nvta_pkg::S_DIV_WAIT))
    else $error("divider finished outside of a division step");

endmodule

/* design/nvta_ram.sv */
// ----------------------------------------------------------------------------
// nvta_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module nvta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/nvta_div.sv */
// ----------------------------------------------------------------------------
// nvta_div: serial restoring divider
// Produces one quotient bit per cycle; done pulses once all SUM_W quotient bits are in.
// ----------------------------------------------------------------------------
module nvta_div (
  input  logic               clk,
  input  logic               rst_n,
  input  nvta_pkg::div_req_t req,
  output nvta_pkg::div_rsp_t rsp
);

  logic               busy_r;
  logic               done_r;
  nvta_pkg::dcnt_t    cnt_r;
  nvta_pkg::divisor_t divisor_r;
  nvta_pkg::divisor_t rem_r;
  nvta_pkg::divisor_t rem_nxt;
  nvta_pkg::sum_t     quo_r;
  logic [nvta_pkg::DIV_W:0] trial;
  logic               ge;

  // The dividend shifts out of the top of quo_r while quotient bits enter below.
  always_comb begin
    trial   = {rem_r, quo_r[nvta_pkg::SUM_W-1]};
    ge      = (trial >= {1'b0, divisor_r});
    rem_nxt = ge ? nvta_pkg::divisor_t'(trial - {1'b0, divisor_r})
                 : trial[nvta_pkg::DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + nvta_pkg::dcnt_t'(1);
        if (cnt_r == nvta_pkg::DCNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r     <= '0;
      quo_r     <= req.dividend;
      divisor_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[nvta_pkg::SUM_W-2:0], ge};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

/* dv/node_value_table_averager_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// node_value_table_averager_checker: result predictor and comparator
// Watches both channels, keeps its own node table, predicts the result of
// every accepted item and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module node_value_table_averager_checker
  import nvta_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  nvta_in_if   in_mon,
  nvta_out_if  out_mon,
  output int   fail_count,
  output int   pending,
  output int   added_count,
  output int   updated_count,
  output int   dropped_count,
  output int   report_count
);

  typedef struct packed {
    status_t             status;
    ncount_t             node_count;
    logic [TEMP_W-1:0]   avg_temp;
    logic [LIGHT_W-1:0]  avg_light;
    logic [POT_W-1:0]    avg_pot;
  } node_result_t;

  logic [ID_W-1:0]    node_ids    [ENTRIES];
  logic [TEMP_W-1:0]  node_temps  [ENTRIES];
  logic [LIGHT_W-1:0] node_lights [ENTRIES];
  logic [POT_W-1:0]   node_pots   [ENTRIES];
  int unsigned        nodes_held;

  node_result_t awaited_results [$];

  // Applies one item to the node table and returns the result it should give.
  function automatic node_result_t apply_node_item(
    op_t op, logic [ID_W-1:0] id, logic [TEMP_W-1:0] rt, logic [LIGHT_W-1:0] rl,
    logic [POT_W-1:0] rp, logic [OWN_W-1:0] ot, logic [OWN_W-1:0] ol,
    logic [POT_W-1:0] opot
  );
    node_result_t res;
    int unsigned  sum_temp, sum_light, sum_pot;
    int           hit;
    res = '0;
    hit = -1;
    if (op == OP_REPORT) begin
      sum_temp  = ot;
      sum_light = ol;
      sum_pot   = opot;
      for (int k = 0; k < int'(nodes_held); k++) begin
        sum_temp  += node_temps[k];
        sum_light += node_lights[k];
        sum_pot   += node_pots[k];
      end
      res.status     = STAT_REPORT;
      res.node_count = NCOUNT_W'(nodes_held);
      res.avg_temp   = TEMP_W'(sum_temp / (nodes_held + 1));
      res.avg_light  = LIGHT_W'(sum_light / (nodes_held + 1));
      res.avg_pot    = POT_W'(sum_pot / (nodes_held + 1));
      nodes_held     = 0;
    end else begin
      for (int k = 0; k < int'(nodes_held); k++) begin
        if (hit < 0 && node_ids[k] == id) hit = k;
      end
      if (hit >= 0) begin
        node_temps[hit]  = rt;
        node_lights[hit] = rl;
        node_pots[hit]   = rp;
        res.status       = STAT_UPDATED;
      end else if (nodes_held < ENTRIES) begin
        node_ids[nodes_held]    = id;
        node_temps[nodes_held]  = rt;
        node_lights[nodes_held] = rl;
        node_pots[nodes_held]   = rp;
        nodes_held++;
        res.status = STAT_ADDED;
      end else begin
        res.status = STAT_DROPPED;
      end
      res.node_count = NCOUNT_W'(nodes_held);
    end
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    node_result_t want;
    if (!rst_n) begin
      nodes_held = 0;
      awaited_results.delete();
      pending <= 0;
    end else begin
      // Results leave before the item taken at this edge can have any effect.
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with no item outstanding");
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", 32'(want.status), 32'(out_mon.status));
          check_field("node_count", 32'(want.node_count), 32'(out_mon.node_count));
          check_field("avg_temp", 32'(want.avg_temp), 32'(out_mon.avg_temp));
          check_field("avg_light", 32'(want.avg_light), 32'(out_mon.avg_light));
          check_field("avg_pot", 32'(want.avg_pot), 32'(out_mon.avg_pot));
          case (want.status)
            STAT_ADDED:   added_count++;
            STAT_UPDATED: updated_count++;
            STAT_DROPPED: dropped_count++;
            default:      report_count++;
          endcase
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        awaited_results.push_back(apply_node_item(op_t'(in_mon.operation), in_mon.node_id,
          in_mon.rx_temp, in_mon.rx_light, in_mon.rx_pot, in_mon.own_temp,
          in_mon.own_light, in_mon.own_pot));
      end
      pending <= awaited_results.size();
    end
  end

endmodule

/* dv/node_value_table_averager_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// node_value_table_averager_test: testbench top of the node value table
// Drives directed and random message and report items with random gaps on
// both channels and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module node_value_table_averager_test;
  import nvta_pkg::*;

  localparam int ITEM_TARGET  = 1800;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES  = 500;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   added_count;
  int   updated_count;
  int   dropped_count;
  int   report_count;
  int   items_sent;

  nvta_in_if  in_ch ();
  nvta_out_if out_ch ();

  node_value_table_averager dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  node_value_table_averager_checker table_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .pending       (pending),
    .added_count   (added_count),
    .updated_count (updated_count),
    .dropped_count (dropped_count),
    .report_count  (report_count)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 70);
  endfunction

  // Every fourth stretch of 100 out of 400 transfers runs without gaps.
  function automatic bit calm_phase(int n);
    return (n % 400) >= 300;
  endfunction

  function automatic logic [31:0] rand_field(int w);
    logic [31:0] ones;
    int          roll;
    ones = (32'd1 << w) - 32'd1;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return ones;
    return $urandom() & ones;
  endfunction

  task automatic send_item(
    op_t op, logic [ID_W-1:0] id, logic [TEMP_W-1:0] rt, logic [LIGHT_W-1:0] rl,
    logic [POT_W-1:0] rp, logic [OWN_W-1:0] ot, logic [OWN_W-1:0] ol,
    logic [POT_W-1:0] opot
  );
    int gap;
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.node_id   <= id;
    in_ch.rx_temp   <= rt;
    in_ch.rx_light  <= rl;
    in_ch.rx_pot    <= rp;
    in_ch.own_temp  <= ot;
    in_ch.own_light <= ol;
    in_ch.own_pot   <= opot;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    gap = calm_phase(items_sent) ? 0 : pick_gap();
    // Valid stays high when the next item follows at once.
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_message(logic [ID_W-1:0] id);
    send_item(OP_MESSAGE, id, TEMP_W'(rand_field(TEMP_W)), LIGHT_W'(rand_field(LIGHT_W)),
      POT_W'(rand_field(POT_W)), OWN_W'(rand_field(OWN_W)), OWN_W'(rand_field(OWN_W)),
      POT_W'(rand_field(POT_W)));
  endtask

  task automatic send_report();
    send_item(OP_REPORT, ID_W'(rand_field(ID_W)), TEMP_W'(rand_field(TEMP_W)),
      LIGHT_W'(rand_field(LIGHT_W)), POT_W'(rand_field(POT_W)), OWN_W'(rand_field(OWN_W)),
      OWN_W'(rand_field(OWN_W)), POT_W'(rand_field(POT_W)));
  endtask

  // One round is a run of messages followed by the report that empties the table.
  task automatic run_round(bit fill);
    logic [ID_W-1:0] pool [8];
    logic [ID_W-1:0] id;
    int              msgs;
    int              roll;
    foreach (pool[i]) pool[i] = ID_W'(rand_field(ID_W));
    roll = $urandom_range(0, 99);
    if (fill) msgs = $urandom_range(34, 44);
    else if (roll < 5) msgs = 0;
    else if (roll < 70) msgs = $urandom_range(1, 20);
    else if (roll < 88) msgs = $urandom_range(21, 31);
    else msgs = $urandom_range(32, 44);
    for (int m = 0; m < msgs; m++) begin
      // Long rounds use mostly fresh identifiers so that the table overflows.
      if ($urandom_range(0, 99) < (msgs > 31 ? 15 : 45)) id = pool[$urandom_range(0, 7)];
      else id = ID_W'($urandom());
      send_message(id);
    end
    send_report();
  endtask

  initial begin : stimulus
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_MESSAGE;
    in_ch.node_id   <= '0;
    in_ch.rx_temp   <= '0;
    in_ch.rx_light  <= '0;
    in_ch.rx_pot    <= '0;
    in_ch.own_temp  <= '0;
    in_ch.own_light <= '0;
    in_ch.own_pot   <= '0;
    items_sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reports on an empty table return the local readings.
    send_item(OP_REPORT, '0, '0, '0, '0, '0, '0, '0);
    send_item(OP_REPORT, '1, '1, '1, '1, '1, '1, '1);
    // Extreme identifiers and values; the local readings must be ignored.
    send_item(OP_MESSAGE, '0, '0, '0, '0, '1, '1, '1);
    send_item(OP_MESSAGE, '1, '1, '1, '1, '0, '0, '0);
    send_item(OP_MESSAGE, '0, '1, '1, '1, '1, '1, '1);
    send_item(OP_MESSAGE, 29'h0AAA_AAAA, 16'h5555, 16'h5555, 8'h55, '0, '1, '0);
    send_item(OP_MESSAGE, 29'h1555_5555, 16'hAAAA, 16'hAAAA, 8'hAA, '1, '0, '1);
    send_item(OP_MESSAGE, '1, 16'h0001, 16'h0001, 8'h01, '0, '0, '0);
    // The received fields of a report must not enter the means.
    send_item(OP_REPORT, '1, '1, '1, '1, '1, '1, '1);
    send_item(OP_REPORT, '0, '1, '1, '1, '0, '0, '0);

    run_round(1'b1);
    while (items_sent < ITEM_TARGET) run_round(1'b0);
    in_ch.valid <= 1'b0;

    // The count of outstanding items is registered and settles at the edge after the last transfer.
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d items: %0d appends, %0d updates, %0d drops on a full table,",
      items_sent, added_count, updated_count, dropped_count);
    $display("and %0d reports, with random gaps and long output stalls.", report_count);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : result_sink
    int  taken;
    int  stall_left;
    int  next_hold_at;
    logic take_next;
    taken        = 0;
    stall_left   = 0;
    next_hold_at = 250;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (out_ch.valid && out_ch.ready) taken++;
      // A long hold lets the block take one more item and then stall its input.
      if (taken >= next_hold_at) begin
        stall_left   = HOLD_CYCLES;
        next_hold_at += 850;
      end else if (stall_left == 0 && !calm_phase(taken) && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      take_next = (stall_left == 0);
      if (stall_left > 0) stall_left--;
      out_ch.ready <= take_next;
      @(posedge clk);
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* sim.f */
design/nvta_pkg.sv
design/nvta_if.sv
design/nvta_ram.sv
design/nvta_div.sv
design/node_value_table_averager.sv
dv/node_value_table_averager_checker.sv
dv/node_value_table_averager_test.sv
